// ===== hw/rtl/lsb_stego_payload_extractor_macros.svh =====
// ----------------------------------------------------------------------------
// LSB stego payload extractor assertion macros
// Concurrent check helpers used at the end of the top level. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_MACROS_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LSBX_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
// Next-cycle implication.
`define LSBX_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define LSBX_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define LSBX_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/lsbx_pkg.sv =====
// ----------------------------------------------------------------------------
// LSB stego payload extractor package
// Types and constants shared by the parser, the result queue and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbx_pkg;

   // Parser phases, one-hot.
   typedef enum logic [7:0] {
      PH_HEADER  = 8'b0000_0001,
      PH_MAGIC   = 8'b0000_0010,
      PH_EXTLEN  = 8'b0000_0100,
      PH_EXT     = 8'b0000_1000,
      PH_SIZE    = 8'b0001_0000,
      PH_PAYLOAD = 8'b0010_0000,
      PH_DONE    = 8'b0100_0000,
      PH_ERROR   = 8'b1000_0000
   } phase_type;

   // Result kinds.
   localparam logic [1:0] KIND_EXT  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;
   localparam logic [1:0] KIND_SIZE = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_MAGIC  = 2'd0;
   localparam logic [1:0] ERR_EXTLEN = 2'd1;
   localparam logic [1:0] ERR_SIZE   = 2'd2;

   // Register indexes.
   localparam logic [1:0] CSR_MAGIC_WORD   = 2'd0;
   localparam logic [1:0] CSR_MAGIC_LENGTH = 2'd1;
   localparam logic [1:0] CSR_HEADER_BYTES = 2'd2;
   localparam logic [1:0] CSR_EXT_LIMIT    = 2'd3;

   // Register reset values.
   localparam logic [63:0] MAGIC_WORD_RESET   = 64'd0;
   localparam logic [3:0]  MAGIC_LENGTH_RESET = 4'd2;
   localparam logic [9:0]  HEADER_BYTES_RESET = 10'd54;
   localparam logic [7:0]  EXT_LIMIT_RESET    = 8'd8;

   // Most magic bytes that are ever checked.
   localparam logic [3:0]  MAGIC_MAX = 4'd8;

   typedef struct packed {
      logic [63:0] magic_word;
      logic [3:0]  magic_length;
      logic [9:0]  header_bytes;
      logic [7:0]  extension_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  out_byte;
      logic [30:0] out_size;
      logic [1:0]  error_code;
      logic        last;
   } result_type;

   // Parser status seen by the top level checks.
   typedef struct packed {
      phase_type  phase;
      logic       in_valid;
      logic       in_frame_start;
      logic       push;
      logic [1:0] push_kind;
      logic       push_last;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lsbx_parser.sv =====
// ----------------------------------------------------------------------------
// LSB stego parser
// Input register plus the parsing state machine. One image byte is handled
// per cycle while the queue has space: header skip, bit gathering and field
// decode all happen in the logic between the input register and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbx_parser import lsbx_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_image_byte,
   input  wire logic       in_frame_start,
   input  wire logic       queue_space,
   output logic            push,
   output result_type      push_data,
   output status_type      status
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_frame_ff;

   phase_type   phase_ff, phase_in;
   logic [9:0]  header_count_ff, header_count_in;
   logic [2:0]  bit_index_ff, bit_index_in;
   logic [7:0]  bit_acc_ff, bit_acc_in;
   logic [7:0]  field_count_ff, field_count_in;
   logic [31:0] word_acc_ff, word_acc_in;
   logic [7:0]  ext_length_ff, ext_length_in;
   logic [30:0] remaining_ff, remaining_in;

   logic        advance;
   logic        carry;
   logic [7:0]  byte_value;
   logic [7:0]  magic_want;
   logic [3:0]  magic_count;
   logic        res_valid;
   result_type  res;

   assign advance  = in_valid_ff && queue_space;
   assign in_ready = !in_valid_ff || queue_space;
   assign in_valid_in = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   assign magic_count = (cfg.magic_length > MAGIC_MAX) ? MAGIC_MAX : cfg.magic_length;

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      bit_index_in    = bit_index_ff;
      bit_acc_in      = bit_acc_ff;
      field_count_in  = field_count_ff;
      word_acc_in     = word_acc_ff;
      ext_length_in   = ext_length_ff;
      remaining_in    = remaining_ff;
      res_valid       = 1'b0;
      res             = '0;
      carry           = 1'b1;
      byte_value      = {in_byte_ff[0], bit_acc_ff[6:0]};
      magic_want      = '0;

      // A frame start clears the parser before its byte is looked at.
      if (in_frame_ff) begin
         phase_in        = PH_HEADER;
         header_count_in = '0;
         bit_index_in    = '0;
         bit_acc_in      = '0;
         field_count_in  = '0;
         word_acc_in     = '0;
         ext_length_in   = '0;
         remaining_in    = '0;
      end

      if (phase_in == PH_HEADER) begin
         if (header_count_in < cfg.header_bytes) begin
            header_count_in = header_count_in + 10'd1;
            carry = 1'b0;
         end else begin
            // The first byte past the header already carries hidden data.
            phase_in       = (magic_count != 4'd0) ? PH_MAGIC : PH_EXTLEN;
            field_count_in = '0;
            word_acc_in    = '0;
         end
      end

      if (phase_in == PH_DONE || phase_in == PH_ERROR) begin
         carry = 1'b0;
      end

      if (carry) begin
         if (bit_index_in != 3'd7) begin
            bit_acc_in[bit_index_in] = in_byte_ff[0];
            bit_index_in = bit_index_in + 3'd1;
         end else begin
            byte_value   = {in_byte_ff[0], bit_acc_in[6:0]};
            bit_index_in = '0;
            bit_acc_in   = '0;
            magic_want   = cfg.magic_word[{field_count_in[2:0], 3'b000} +: 8];
            unique case (phase_in)
               PH_MAGIC: begin
                  if (byte_value != magic_want) begin
                     phase_in       = PH_ERROR;
                     res_valid      = 1'b1;
                     res.out_kind   = KIND_ERR;
                     res.error_code = ERR_MAGIC;
                  end else begin
                     field_count_in = field_count_in + 8'd1;
                     if (field_count_in >= {4'd0, magic_count}) begin
                        phase_in       = PH_EXTLEN;
                        field_count_in = '0;
                        word_acc_in    = '0;
                     end
                  end
               end
               PH_EXTLEN: begin
                  word_acc_in = word_acc_in |
                     ({24'd0, byte_value} << {field_count_in[1:0], 3'b000});
                  field_count_in = field_count_in + 8'd1;
                  if (field_count_in >= 8'd4) begin
                     if (word_acc_in == 32'd0 || word_acc_in[31] ||
                         word_acc_in >= {24'd0, cfg.extension_limit}) begin
                        phase_in       = PH_ERROR;
                        res_valid      = 1'b1;
                        res.out_kind   = KIND_ERR;
                        res.error_code = ERR_EXTLEN;
                     end else begin
                        ext_length_in  = word_acc_in[7:0];
                        phase_in       = PH_EXT;
                        field_count_in = '0;
                     end
                  end
               end
               PH_EXT: begin
                  field_count_in = field_count_in + 8'd1;
                  if (field_count_in >= ext_length_in) begin
                     phase_in       = PH_SIZE;
                     field_count_in = '0;
                     word_acc_in    = '0;
                  end
                  res_valid    = 1'b1;
                  res.out_kind = KIND_EXT;
                  res.out_byte = byte_value;
               end
               PH_SIZE: begin
                  word_acc_in = word_acc_in |
                     ({24'd0, byte_value} << {field_count_in[1:0], 3'b000});
                  field_count_in = field_count_in + 8'd1;
                  if (field_count_in >= 8'd4) begin
                     res_valid = 1'b1;
                     if (word_acc_in == 32'd0 || word_acc_in[31]) begin
                        phase_in       = PH_ERROR;
                        res.out_kind   = KIND_ERR;
                        res.error_code = ERR_SIZE;
                     end else begin
                        remaining_in   = word_acc_in[30:0];
                        phase_in       = PH_PAYLOAD;
                        field_count_in = '0;
                        res.out_kind   = KIND_SIZE;
                        res.out_size   = word_acc_in[30:0];
                     end
                  end
               end
               PH_PAYLOAD: begin
                  remaining_in = remaining_in - 31'd1;
                  res_valid    = 1'b1;
                  res.out_kind = KIND_DATA;
                  res.out_byte = byte_value;
                  if (remaining_in == 31'd0) begin
                     phase_in = PH_DONE;
                     res.last = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign push      = advance && res_valid;
   assign push_data = res;

   assign status.phase          = phase_ff;
   assign status.in_valid       = in_valid_ff;
   assign status.in_frame_start = in_frame_ff;
   assign status.push           = push;
   assign status.push_kind      = res.out_kind;
   assign status.push_last      = res.last;

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         in_byte_ff  <= in_image_byte;
         in_frame_ff <= in_frame_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         phase_ff        <= PH_HEADER;
         header_count_ff <= '0;
         bit_index_ff    <= '0;
         bit_acc_ff      <= '0;
         field_count_ff  <= '0;
         word_acc_ff     <= '0;
         ext_length_ff   <= '0;
         remaining_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff        <= phase_in;
            header_count_ff <= header_count_in;
            bit_index_ff    <= bit_index_in;
            bit_acc_ff      <= bit_acc_in;
            field_count_ff  <= field_count_in;
            word_acc_ff     <= word_acc_in;
            ext_length_ff   <= ext_length_in;
            remaining_ff    <= remaining_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lsbx_result_queue.sv =====
// ----------------------------------------------------------------------------
// LSB stego result queue
// Two-entry output queue. The head entry drives the result port; the second
// entry catches a result while the head waits, so the parser keeps going.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbx_result_queue import lsbx_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            space,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_data
);

   logic [1:0] count_ff, count_in;
   result_type head_ff;
   result_type spare_ff;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign space     = (count_ff != 2'd2);
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (pop) begin
         head_ff <= (count_ff == 2'd2) ? spare_ff : push_data;
      end else if (push && count_ff == 2'd0) begin
         head_ff <= push_data;
      end
      if (!pop && push && count_ff == 2'd1) begin
         spare_ff <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lsb_stego_payload_extractor.sv =====
// ----------------------------------------------------------------------------
// LSB stego payload extractor
// Recovers the hidden extension and payload from a stego image stream.
// ----------------------------------------------------------------------------
// The block takes one image byte per cycle and sustains that rate as long as
// results are taken. An accepted byte is parsed in the next cycle while it
// sits in the input register; its result (if any) goes to the result queue,
// whose head drives rsp_. Ready drops only while a byte waits in the input
// register and the two-entry result queue is full. A frame start flag on
// req_tuser restarts parsing with that byte. The user must write registers
// through the csr_ port only while no item is in flight; nothing enforces it.
`default_nettype none
`include "lsb_stego_payload_extractor_macros.svh"

module lsb_stego_payload_extractor import lsbx_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] image_byte
   input  wire logic        req_tuser,   // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [7:0] out_byte, [38:8] out_size,
                                         // [40:39] error_code, zero above
   output logic [1:0]       rsp_tuser,   // [1:0] out_kind
   output logic             rsp_tlast,   // last
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   cfg_type    cfg_ff;
   logic       q_space;
   logic       push;
   result_type push_data;
   result_type out_data;
   status_type status;
   logic       parser_stopped;
   logic       push_error;
   logic       push_final;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word      <= MAGIC_WORD_RESET;
         cfg_ff.magic_length    <= MAGIC_LENGTH_RESET;
         cfg_ff.header_bytes    <= HEADER_BYTES_RESET;
         cfg_ff.extension_limit <= EXT_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAGIC_WORD:   cfg_ff.magic_word      <= csr_wdata;
            CSR_MAGIC_LENGTH: cfg_ff.magic_length    <= csr_wdata[3:0];
            CSR_HEADER_BYTES: cfg_ff.header_bytes    <= csr_wdata[9:0];
            CSR_EXT_LIMIT:    cfg_ff.extension_limit <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   lsbx_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_image_byte  (req_tdata),
      .in_frame_start (req_tuser),
      .queue_space    (q_space),
      .push           (push),
      .push_data      (push_data),
      .status         (status)
   );

   lsbx_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .space     (q_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {7'd0, out_data.error_code, out_data.out_size, out_data.out_byte};
   assign rsp_tuser = out_data.out_kind;
   assign rsp_tlast = out_data.last;

   assign parser_stopped = status.in_valid && !status.in_frame_start &&
                           (status.phase == PH_DONE || status.phase == PH_ERROR);
   assign push_error     = status.push && (status.push_kind == KIND_ERR);
   assign push_final     = status.push && status.push_last;

   `LSBX_ASSERT_IMPLY(a_push_has_room, clock, reset, status.push, q_space)
   `LSBX_ASSERT_IMPLY(a_quiet_after_stop, clock, reset, parser_stopped, !status.push)
   `LSBX_ASSERT_NEXT(a_error_stops, clock, reset, push_error, status.phase == PH_ERROR)
   `LSBX_ASSERT_NEXT(a_last_ends_frame, clock, reset, push_final, status.phase == PH_DONE)

endmodule

`default_nettype wire

// ===== verif/lsb_stego_payload_extractor_tb.sv =====
// ----------------------------------------------------------------------------
// LSB stego payload extractor testbench
// Builds stego images from hidden fields (magic, extension length, extension,
// payload size, payload), streams them into the block with random idling on
// both sides, predicts every item the block should emit and checks each one
// field by field as it is taken from the result port.
// ----------------------------------------------------------------------------
module lsb_stego_payload_extractor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsbx_pkg::*;

   localparam int SETTLE_CYCLES  = 4;
   localparam int LONG_HOLD      = 200;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int ITEMS_PER_MODE = 40;

   typedef enum {
      FRM_CLEAN,
      FRM_BAD_MAGIC,
      FRM_BAD_EXTLEN,
      FRM_BAD_SIZE,
      FRM_CUT,
      FRM_NOISE
   } frame_shape_type;

   // Predicts what the extractor emits for every accepted image byte and
   // holds those items until the block delivers them.
   class extract_scoreboard;
      logic [63:0] magic_word;
      logic [3:0]  magic_length;
      logic [9:0]  header_bytes;
      logic [7:0]  ext_limit;
      phase_type   phase;
      logic [9:0]  skipped;
      logic [2:0]  bit_pos;
      logic [7:0]  bit_acc;
      logic [31:0] field_count;
      logic [31:0] word_acc;
      logic [7:0]  ext_length;
      logic [30:0] payload_left;
      result_type  expected_results[$];
      int          mismatches;

      function new();
         magic_word   = MAGIC_WORD_RESET;
         magic_length = MAGIC_LENGTH_RESET;
         header_bytes = HEADER_BYTES_RESET;
         ext_limit    = EXT_LIMIT_RESET;
         mismatches   = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         phase        = PH_HEADER;
         skipped      = '0;
         bit_pos      = '0;
         bit_acc      = '0;
         field_count  = '0;
         word_acc     = '0;
         ext_length   = '0;
         payload_left = '0;
      endfunction

      function int unsigned magic_count();
         return (magic_length > MAGIC_MAX) ? MAGIC_MAX : magic_length;
      endfunction

      function void write_reg(logic [1:0] index, logic [63:0] value);
         case (index)
            CSR_MAGIC_WORD:   magic_word   = value;
            CSR_MAGIC_LENGTH: magic_length = value[3:0];
            CSR_HEADER_BYTES: header_bytes = value[9:0];
            CSR_EXT_LIMIT:    ext_limit    = value[7:0];
            default: ;
         endcase
      endfunction

      function void push_result(logic [1:0] kind, logic [7:0] data, logic [30:0] size,
                                logic [1:0] code, logic last_flag);
         result_type r;
         r.out_kind   = kind;
         r.out_byte   = data;
         r.out_size   = size;
         r.error_code = code;
         r.last       = last_flag;
         expected_results.push_back(r);
      endfunction

      function void raise_error(logic [1:0] code);
         phase = PH_ERROR;
         push_result(KIND_ERR, '0, '0, code, 1'b0);
      endfunction

      function void note_input(logic [7:0] img, logic fs);
         logic [7:0] hidden;
         if (fs) restart_frame();
         if (phase == PH_HEADER) begin
            if (skipped < header_bytes) begin
               skipped++;
               return;
            end
            // The first byte past the header already carries hidden data.
            phase = (magic_count() > 0) ? PH_MAGIC : PH_EXTLEN;
            field_count = '0;
            word_acc    = '0;
         end
         if (phase == PH_DONE || phase == PH_ERROR) return;
         bit_acc[bit_pos] = img[0];
         if (bit_pos < 3'd7) begin
            bit_pos++;
            return;
         end
         hidden  = bit_acc;
         bit_pos = '0;
         bit_acc = '0;
         case (phase)
            PH_MAGIC: begin
               if (hidden != magic_word[8*field_count[2:0] +: 8]) begin
                  raise_error(ERR_MAGIC);
                  return;
               end
               field_count++;
               if (field_count >= magic_count()) begin
                  phase       = PH_EXTLEN;
                  field_count = '0;
                  word_acc    = '0;
               end
            end
            PH_EXTLEN: begin
               word_acc = word_acc | (32'(hidden) << (8 * field_count[1:0]));
               field_count++;
               if (field_count >= 4) begin
                  // The length is signed, so a set top bit is a negative length.
                  if (word_acc == 0 || word_acc[31] || word_acc >= 32'(ext_limit)) begin
                     raise_error(ERR_EXTLEN);
                  end else begin
                     ext_length  = word_acc[7:0];
                     phase       = PH_EXT;
                     field_count = '0;
                  end
               end
            end
            PH_EXT: begin
               field_count++;
               if (field_count >= 32'(ext_length)) begin
                  phase       = PH_SIZE;
                  field_count = '0;
                  word_acc    = '0;
               end
               push_result(KIND_EXT, hidden, '0, '0, 1'b0);
            end
            PH_SIZE: begin
               word_acc = word_acc | (32'(hidden) << (8 * field_count[1:0]));
               field_count++;
               if (field_count >= 4) begin
                  if (word_acc == 0 || word_acc[31]) begin
                     raise_error(ERR_SIZE);
                  end else begin
                     payload_left = word_acc[30:0];
                     phase        = PH_PAYLOAD;
                     field_count  = '0;
                     push_result(KIND_SIZE, '0, payload_left, '0, 1'b0);
                  end
               end
            end
            PH_PAYLOAD: begin
               payload_left--;
               if (payload_left == 0) begin
                  phase = PH_DONE;
                  push_result(KIND_DATA, hidden, '0, '0, 1'b1);
               end else begin
                  push_result(KIND_DATA, hidden, '0, '0, 1'b0);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: kind %0d byte %02h size %0d code %0d last %0b",
                        got.out_kind, got.out_byte, got.out_size, got.error_code, got.last);
            return;
         end
         want = expected_results.pop_front();
         if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
             got.out_size !== want.out_size || got.error_code !== want.error_code ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected kind %0d byte %02h size %0d code %0d last %0b",
                        want.out_kind, want.out_byte, want.out_size, want.error_code,
                        want.last);
               $display("          actual   kind %0d byte %02h size %0d code %0d last %0b",
                        got.out_kind, got.out_byte, got.out_size, got.error_code, got.last);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] image_byte
   logic        req_tuser  = 1'b0; // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [7:0] out_byte, [38:8] out_size, [40:39] error_code
   logic [1:0]  rsp_tuser;         // [1:0] out_kind
   logic        rsp_tlast;
   logic        csr_wr_en  = 1'b0;
   logic [1:0]  csr_index  = CSR_MAGIC_WORD;
   logic [63:0] csr_wdata  = '0;

   extract_scoreboard board;
   logic [7:0]        frame_q[$];
   int                items_sent    = 0;
   bit                sender_calm   = 1'b0;
   bit                receiver_calm = 1'b0;
   bit                hold_request  = 1'b0;

   lsb_stego_payload_extractor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: random stalls, calm stretches, and one long hold-off on request.
   initial begin : result_sink
      int         stall;
      result_type got;
      do @(posedge clock); while (reset);
      forever begin
         stall = receiver_calm ? 0 : $urandom_range(0, 5);
         if (hold_request) begin
            stall        = LONG_HOLD;
            hold_request = 1'b0;
         end
         if ($urandom_range(0, 15) == 0) receiver_calm = !receiver_calm;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.out_kind   = rsp_tuser;
         got.out_byte   = rsp_tdata[7:0];
         got.out_size   = rsp_tdata[38:8];
         got.error_code = rsp_tdata[40:39];
         got.last       = rsp_tlast;
         board.check_result(got);
      end
   end

   task automatic send_item(logic [7:0] img, logic fs);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= img;
      req_tuser  <= fs;
      do @(posedge clock); while (!req_tready);
      board.note_input(img, fs);
      items_sent++;
   endtask

   // Stops offering items until every expected item has come out, then lets
   // bytes that cause no item leave the pipeline.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame(logic first_fs, int pause_at);
      foreach (frame_q[i]) begin
         if (i == pause_at) drain();
         send_item(frame_q[i], (i == 0) ? first_fs : 1'b0);
      end
      frame_q.delete();
   endtask

   task automatic write_csr(logic [1:0] index, logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(index, value);
   endtask

   task automatic set_config(logic [63:0] word, logic [3:0] count, logic [9:0] skip,
                             logic [7:0] limit);
      drain();
      write_csr(CSR_MAGIC_WORD, word);
      write_csr(CSR_MAGIC_LENGTH, 64'(count));
      write_csr(CSR_HEADER_BYTES, 64'(skip));
      write_csr(CSR_EXT_LIMIT, 64'(limit));
      csr_wr_en <= 1'b0;
   endtask

   function automatic void push_header(int n);
      repeat (n) frame_q.push_back(8'($urandom));
   endfunction

   // Each hidden bit rides in the LSB of one image byte, bit 0 first.
   function automatic void push_hidden(logic [7:0] value);
      for (int b = 0; b < 8; b++) frame_q.push_back({7'($urandom), value[b]});
   endfunction

   function automatic void push_word(logic [31:0] word);
      for (int k = 0; k < 4; k++) push_hidden(word[8*k +: 8]);
   endfunction

   function automatic void build_frame(int skip, int bad_magic, logic [31:0] ext_word,
                                       int ext_chars, logic [31:0] size_word, int pay_bytes);
      logic [7:0] flip;
      push_header(skip);
      for (int k = 0; k < int'(board.magic_count()); k++) begin
         flip = (k == bad_magic) ? 8'($urandom_range(1, 255)) : 8'h00;
         push_hidden(board.magic_word[8*k +: 8] ^ flip);
      end
      push_word(ext_word);
      repeat (ext_chars) push_hidden(8'($urandom));
      push_word(size_word);
      repeat (pay_bytes) push_hidden(8'($urandom));
   endfunction

   task automatic random_frame();
      frame_shape_type shape;
      int              roll;
      int              ext_n;
      int              pay_n;
      int              bad_idx;
      int              pause_at;
      logic [31:0]     ext_word;
      logic [31:0]     size_word;
      roll  = $urandom_range(0, 99);
      shape = (roll < 55) ? FRM_CLEAN : (roll < 63) ? FRM_BAD_MAGIC :
              (roll < 71) ? FRM_BAD_EXTLEN : (roll < 79) ? FRM_BAD_SIZE :
              (roll < 93) ? FRM_CUT : FRM_NOISE;
      sender_calm = ($urandom_range(0, 3) == 0);
      if (shape == FRM_NOISE) begin
         repeat ($urandom_range(8, 48))
            send_item(8'($urandom), $urandom_range(0, 11) == 0);
         return;
      end
      ext_n = (board.ext_limit < 2) ? 1 :
              $urandom_range(1, (board.ext_limit > 7) ? 6 : board.ext_limit - 1);
      pay_n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      ext_word  = ext_n;
      size_word = pay_n;
      bad_idx   = -1;
      case (shape)
         FRM_BAD_MAGIC:
            bad_idx = $urandom_range(0, (board.magic_count() > 0) ?
                                        board.magic_count() - 1 : 0);
         FRM_BAD_EXTLEN:
            case ($urandom_range(0, 3))
               0:       ext_word = '0;
               1:       ext_word = {1'b1, 31'($urandom)};
               2:       ext_word = 32'(board.ext_limit);
               default: ext_word = {1'b0, 31'($urandom)} | 32'h100;
            endcase
         FRM_BAD_SIZE:
            size_word = $urandom_range(0, 1) ? 32'h0 : {1'b1, 31'($urandom)};
         FRM_CUT:
            if ($urandom_range(0, 2) == 0) size_word = {1'b0, 31'($urandom)} | 32'h1000;
         default: ;
      endcase
      build_frame(board.header_bytes, bad_idx, ext_word, ext_n, size_word, pay_n);
      if (shape == FRM_CUT) frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 1)];
      // Bytes past the end of a frame must be ignored.
      if ($urandom_range(0, 3) == 0) push_header($urandom_range(1, 12));
      pause_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, frame_q.size() - 1) : -1;
      send_frame($urandom_range(0, 9) != 0, pause_at);
   endtask

   initial begin : stimulus
      int start;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset behaves as a frame start: first frame has no start flag.
      build_frame(54, -1, 32'd1, 1, 32'd1, 1);
      send_frame(1'b0, -1);

      // Header register lowered in the middle of the header skip.
      push_header(20);
      send_frame(1'b1, -1);
      drain();
      write_csr(CSR_HEADER_BYTES, 64'd10);
      csr_wr_en <= 1'b0;
      build_frame(0, -1, 32'd1, 1, 32'd1, 1);
      push_header(8);
      send_frame(1'b0, -1);

      // Full-width magic with a mismatch on the last magic byte.
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 10'd0, 8'd8);
      build_frame(0, 7, 32'd1, 1, 32'd1, 1);
      send_frame(1'b1, -1);

      // Length errors and the largest payload size, with no magic.
      set_config(64'h0, 4'd0, 10'd0, 8'd8);
      build_frame(0, -1, 32'd8, 1, 32'd1, 1);
      send_frame(1'b1, -1);
      build_frame(0, -1, 32'h8000_0001, 1, 32'd1, 1);
      send_frame(1'b1, -1);
      build_frame(0, -1, 32'd2, 2, 32'd0, 1);
      send_frame(1'b1, -1);
      build_frame(0, -1, 32'd1, 1, 32'hFFFF_FFFF, 1);
      send_frame(1'b1, -1);
      build_frame(0, -1, 32'd1, 1, 32'h7FFF_FFFF, 3);
      send_frame(1'b1, -1);

      // Extension limits of zero and one reject every length; magic length
      // above eight saturates.
      set_config({$urandom, $urandom}, 4'd15, 10'd1, 8'd0);
      build_frame(1, -1, 32'd1, 1, 32'd1, 1);
      frame_q = frame_q[0:8*12];
      send_frame(1'b1, -1);
      set_config({$urandom, $urandom}, 4'd0, 10'd1, 8'd1);
      build_frame(1, -1, 32'd1, 1, 32'd1, 1);
      frame_q = frame_q[0:8*4];
      send_frame(1'b1, -1);

      // No magic, long payload: the result side holds off while the input
      // keeps coming, then the sender pauses until everything is out.
      set_config(64'h0, 4'd0, 10'd0, 8'd2);
      sender_calm  = 1'b1;
      hold_request = 1'b1;
      build_frame(0, -1, 32'd1, 1, 32'd8, 8);
      send_frame(1'b1, 100);
      sender_calm = 1'b0;

      // Widest extension limit.
      set_config({$urandom, $urandom}, 4'd0, 10'd1, 8'd255);
      build_frame(1, -1, 32'd3, 3, 32'd2, 2);
      send_frame(1'b1, -1);
      build_frame(1, -1, 32'd255, 1, 32'd1, 1);
      frame_q = frame_q[0:8*4];
      send_frame(1'b1, -1);

      for (int mode = 0; mode < 5; mode++) begin
         case (mode)
            0: set_config({$urandom, $urandom}, 4'd4, 10'd3, 8'd8);
            1: set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 10'd0, 8'd255);
            2: set_config({$urandom, $urandom}, 4'd0, 10'd1, 8'd2);
            3: set_config({$urandom, $urandom}, 4'd15, 10'd7, 8'd5);
            default: set_config(64'h0, 4'd1, 10'd54, 8'($urandom_range(3, 40)));
         endcase
         start = items_sent;
         while (items_sent - start < ITEMS_PER_MODE) random_frame();
      end

      drain();
      if (board.mismatches == 0 && board.expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
